// ----- design/sysex_dataset_framer_top_assert.svh -----
// assertion macros shared by the framer modules
// each macro expects clk and rst_n in the scope where it is used
`ifndef SYSEX_DATASET_FRAMER_TOP_ASSERT_SVH
`define SYSEX_DATASET_FRAMER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SDF_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdf assertion failed");

// next-cycle implication
`define SDF_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdf assertion failed");

`else

`define SDF_ASSERT_IMP(name, ante, cons)
`define SDF_ASSERT_NXT(name, ante, cons)

`endif

`endif

// ----- design/sdf_pkg.sv -----
package sdf_pkg;

    localparam int SDF_QUEUE_DEPTH = 4;
    localparam int CFG_IDX_W       = 1;

    localparam logic [6:0] DEVICE_ID_RST = 7'h10;
    localparam logic [6:0] MODEL_ID_RST  = 7'h6A;

    localparam logic [7:0] SYX_START   = 8'hF0;
    localparam logic [7:0] SYX_MAKER   = 8'h41;
    localparam logic [7:0] CMD_DT1     = 8'h12;
    localparam logic [7:0] CMD_RQ1     = 8'h11;
    localparam logic [7:0] SYX_END     = 8'hF7;

    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ID = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MODEL_ID  = 1'b1;

    // what follows the header (if any) for one job
    typedef enum logic [2:0] {
        BODY_NONE      = 3'd0,
        BODY_TRIPLE    = 3'd1,
        BODY_REQ       = 3'd2,
        BODY_TAIL_TWO  = 3'd3,
        BODY_TAIL_NONE = 3'd4,
        BODY_TAIL_ONE  = 3'd5
    } body_t;

    typedef struct packed {
        logic        hdr;
        logic        req;
        logic [31:0] addr;
        body_t       body;
        logic [6:0]  g0;
        logic [6:0]  g1;
        logic [6:0]  d;
        logic [6:0]  cs;
    } job_t;

    typedef struct packed {
        logic [6:0] device_id;
        logic [6:0] model_id;
    } cfg_t;

    typedef struct packed {
        logic [1:0] len;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } msg_t;

endpackage

// ----- design/sdf_front.sv -----
module sdf_front
    import sdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        op,
    input  logic [31:0] address,
    input  logic [6:0]  data_value,
    input  logic        last_byte,
    input  logic        q_full,
    output logic        push,
    output job_t        job
);

    logic       in_packet_reg, in_packet_next;
    logic [1:0] group_count_reg, group_count_next;
    logic [6:0] running_sum_reg, running_sum_next;
    logic [6:0] g0_reg, g0_next;
    logic [6:0] g1_reg, g1_next;

    logic       accept;
    logic       start;
    logic [1:0] gc;
    logic [6:0] asum;
    logic [6:0] sum;

    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;

    // seven-bit sum of the four address bytes
    assign asum = address[6:0] + address[14:8] + address[22:16] + address[30:24];

    always_comb
    begin
        start            = !in_packet_reg;
        gc               = start ? 2'd0 : group_count_reg;
        sum              = (start ? asum : running_sum_reg) + data_value;
        in_packet_next   = in_packet_reg;
        group_count_next = group_count_reg;
        running_sum_next = running_sum_reg;
        g0_next          = g0_reg;
        g1_next          = g1_reg;

        job.hdr  = 1'b0;
        job.req  = 1'b0;
        job.addr = address;
        job.body = BODY_NONE;
        job.g0   = g0_reg;
        job.g1   = g1_reg;
        job.d    = data_value;
        job.cs   = 7'd0 - sum;

        if (op)
        begin
            // request packet, abandons any open data-set packet
            job.hdr          = 1'b1;
            job.req          = 1'b1;
            job.body         = BODY_REQ;
            job.cs           = 7'd0 - (asum + data_value);
            in_packet_next   = 1'b0;
            group_count_next = 2'd0;
        end
        else
        begin
            job.hdr          = start;
            running_sum_next = sum;
            if (!last_byte)
            begin
                in_packet_next = 1'b1;
                if (gc == 2'd2)
                begin
                    job.body         = BODY_TRIPLE;
                    group_count_next = 2'd0;
                end
                else
                begin
                    group_count_next = gc + 2'd1;
                    if (gc == 2'd0)
                    begin
                        g0_next = data_value;
                    end
                    else
                    begin
                        g1_next = data_value;
                    end
                end
            end
            else
            begin
                in_packet_next   = 1'b0;
                group_count_next = 2'd0;
                case (gc)
                    2'd2:    job.body = BODY_TAIL_TWO;
                    2'd1:    job.body = BODY_TAIL_ONE;
                    default: job.body = BODY_TAIL_NONE;
                endcase
            end
        end
    end

    assign push = accept && (job.hdr || (job.body != BODY_NONE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg   <= 1'b0;
            group_count_reg <= 2'd0;
            running_sum_reg <= 7'd0;
        end
        else if (accept)
        begin
            in_packet_reg   <= in_packet_next;
            group_count_reg <= group_count_next;
            running_sum_reg <= running_sum_next;
        end
    end

    // group bytes hold no reset value, a slot is written before it is read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            g0_reg <= g0_next;
            g1_reg <= g1_next;
        end
    end

endmodule

// ----- design/sdf_queue.sv -----
`include "sysex_dataset_framer_top_assert.svh"

module sdf_queue
    import sdf_pkg::*;
#(
    parameter int DEPTH = SDF_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_job   = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    `SDF_ASSERT_IMP(a_no_overflow, push, !full || pop)
    `SDF_ASSERT_IMP(a_no_underflow, pop, head_valid)
    `SDF_ASSERT_IMP(a_count_range, 1'b1, count_reg <= CNT_FULL)
    `SDF_ASSERT_NXT(a_push_lands, push && !pop, head_valid)

endmodule

// ----- design/sdf_back.sv -----
`include "sysex_dataset_framer_top_assert.svh"

module sdf_back
    import sdf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       head_valid,
    input  job_t       head_job,
    output logic       pop,
    output logic       msg_valid,
    input  logic       msg_stall,
    output logic [1:0] msg_len,
    output logic [7:0] byte_first,
    output logic [7:0] byte_second,
    output logic [7:0] byte_third,
    output logic       run_end
);

    logic [2:0] step_reg, step_next;
    logic       msg_valid_reg, msg_valid_next;
    msg_t       msg_reg;
    logic       run_end_reg;

    logic [2:0] hdr_len;
    logic [2:0] body_len;
    logic [2:0] last_idx;
    logic [2:0] b_idx;
    logic       step_last;
    logic       load;
    msg_t       cur;
    logic [7:0] cmd;
    logic [7:0] d8, g08, g18, cs8;

    assign hdr_len   = head_job.hdr ? 3'd3 : 3'd0;
    assign last_idx  = hdr_len + body_len - 3'd1;
    assign b_idx     = step_reg - hdr_len;
    assign step_last = (step_reg == last_idx);
    assign load      = head_valid && (!msg_valid_reg || !msg_stall);
    assign pop       = load && step_last;

    assign cmd = head_job.req ? CMD_RQ1 : CMD_DT1;
    assign d8  = {1'b0, head_job.d};
    assign g08 = {1'b0, head_job.g0};
    assign g18 = {1'b0, head_job.g1};
    assign cs8 = {1'b0, head_job.cs};

    always_comb
    begin
        case (head_job.body)
            BODY_TRIPLE:    body_len = 3'd1;
            BODY_REQ:       body_len = 3'd2;
            BODY_TAIL_TWO:  body_len = 3'd2;
            BODY_TAIL_NONE: body_len = 3'd1;
            BODY_TAIL_ONE:  body_len = 3'd2;
            default:        body_len = 3'd0;
        endcase
    end

    // message at the current step of the head job
    always_comb
    begin
        cur = '{len: 2'd3, b0: 8'h00, b1: 8'h00, b2: 8'h00};
        if (head_job.hdr && (step_reg < 3'd3))
        begin
            case (step_reg)
                3'd0:    cur = '{2'd3, SYX_START, SYX_MAKER, {1'b0, cfg.device_id}};
                3'd1:    cur = '{2'd3, {1'b0, cfg.model_id}, cmd, head_job.addr[31:24]};
                default: cur = '{2'd3, head_job.addr[23:16], head_job.addr[15:8],
                                 head_job.addr[7:0]};
            endcase
        end
        else
        begin
            case (head_job.body)
                BODY_TRIPLE:    cur = '{2'd3, g08, g18, d8};
                BODY_REQ:
                begin
                    if (b_idx == 3'd0)
                    begin
                        cur = '{2'd3, 8'h00, 8'h00, 8'h00};
                    end
                    else
                    begin
                        cur = '{2'd3, d8, cs8, SYX_END};
                    end
                end
                BODY_TAIL_TWO:
                begin
                    if (b_idx == 3'd0)
                    begin
                        cur = '{2'd3, g08, g18, d8};
                    end
                    else
                    begin
                        cur = '{2'd2, cs8, SYX_END, 8'h00};
                    end
                end
                BODY_TAIL_NONE: cur = '{2'd3, d8, cs8, SYX_END};
                BODY_TAIL_ONE:
                begin
                    if (b_idx == 3'd0)
                    begin
                        cur = '{2'd3, g08, d8, cs8};
                    end
                    else
                    begin
                        cur = '{2'd1, SYX_END, 8'h00, 8'h00};
                    end
                end
                default:        cur = '{2'd3, 8'h00, 8'h00, 8'h00};
            endcase
        end
    end

    always_comb
    begin
        step_next      = step_reg;
        msg_valid_next = msg_valid_reg && msg_stall;
        if (load)
        begin
            msg_valid_next = 1'b1;
            step_next      = step_last ? 3'd0 : step_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 3'd0;
            msg_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            msg_valid_reg <= msg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            msg_reg     <= cur;
            run_end_reg <= step_last;
        end
    end

    assign msg_valid   = msg_valid_reg;
    assign msg_len     = msg_reg.len;
    assign byte_first  = msg_reg.b0;
    assign byte_second = msg_reg.b1;
    assign byte_third  = msg_reg.b2;
    assign run_end     = run_end_reg;

    `SDF_ASSERT_IMP(a_step_idle, !head_valid, step_reg == 3'd0)
    `SDF_ASSERT_IMP(a_step_range, head_valid, step_reg <= last_idx)
    `SDF_ASSERT_IMP(a_job_nonempty, head_valid, head_job.hdr || (body_len != 3'd0))
    `SDF_ASSERT_IMP(a_len_nonzero, msg_valid_reg, msg_reg.len != 2'd0)

endmodule

// ----- design/sysex_dataset_framer_top.sv -----
// exclusive-packet framer: turns a stream of data-set bytes, or single request
// items, into a run of midi messages of one to three bytes each. a data-set
// packet opens on its first item with a three-message header (f0 41 device,
// model 12 a1, a2 a3 a4), packs data three to a message and closes on the item
// marked last_byte with checksum and f7; a request item emits a whole five
// message packet with command 11. run_end marks the last message of each item.
// the input side takes one item per cycle while the job queue has room; the
// output side issues one message per cycle unless msg_stall holds it; an item
// causes no message for a byte that only fills a group, one for a full group,
// up to five for a header plus tail or a request. the back-end sequencer sets
// the sustained rate. the user must write device_id and model_id through the
// cfg port (index 0 and 1) only while idle; the block does not enforce this.
module sysex_dataset_framer_top
    import sdf_pkg::*;
#(
    parameter int QUEUE_DEPTH = SDF_QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [6:0]           cfg_data,
    // input items
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic                 op,
    input  logic [31:0]          address,
    input  logic [6:0]           data_value,
    input  logic                 last_byte,
    // output messages
    output logic                 msg_valid,
    input  logic                 msg_stall,
    output logic [1:0]           msg_len,
    output logic [7:0]           byte_first,
    output logic [7:0]           byte_second,
    output logic [7:0]           byte_third,
    output logic                 run_end
);

    cfg_t cfg_reg;
    logic push;
    logic pop;
    logic q_full;
    logic head_valid;
    job_t push_job;
    job_t head_job;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_id <= DEVICE_ID_RST;
            cfg_reg.model_id  <= MODEL_ID_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DEVICE_ID: cfg_reg.device_id <= cfg_data;
                REG_MODEL_ID:  cfg_reg.model_id  <= cfg_data;
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    // front end: tracks packet state, checksum and byte groups, one item a cycle unless q_full
    sdf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .op         (op),
        .address    (address),
        .data_value (data_value),
        .last_byte  (last_byte),
        .q_full     (q_full),
        .push       (push),
        .job        (push_job)
    );

    // job queue decouples item intake from message output
    sdf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // back end: expands each job into its messages, one per cycle unless msg_stall holds them
    sdf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head_valid  (head_valid),
        .head_job    (head_job),
        .pop         (pop),
        .msg_valid   (msg_valid),
        .msg_stall   (msg_stall),
        .msg_len     (msg_len),
        .byte_first  (byte_first),
        .byte_second (byte_second),
        .byte_third  (byte_third),
        .run_end     (run_end)
    );

endmodule

// ----- tb/tb_sysex_dataset_framer_top.sv -----
module tb_sysex_dataset_framer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sdf_pkg::*;

    // op field values
    localparam logic OP_DATA_SET = 1'b0;
    localparam logic OP_REQUEST  = 1'b1;

    localparam int ITEMS_PER_PHASE = 22;
    localparam int N_PHASES        = 5;
    // cycles to let the job queue and sequencer empty after the last message
    localparam int DRAIN_CYCLES    = 32;
    // cycles with no handshake on any channel before the run is declared hung
    localparam int QUIET_LIMIT     = 2000;

    // one midi message as it leaves the block
    typedef struct packed {
        logic [1:0] len;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       run_end;
    } midi_msg_t;

    // directed row: n_typed nonzero means the messages are spelled out below,
    // all of length three, run_end on the last one
    typedef struct packed {
        logic              op;
        logic [31:0]       addr;
        logic [6:0]        data;
        logic              last;
        logic [2:0]        n_typed;
        logic [0:4][23:0]  typed;
    } dir_row_t;

    localparam logic [0:4][23:0] NO_TYPED = '0;
    localparam int N_DIRECTED = 22;

    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        // request after reset, all zero, checksum zero
        '{OP_REQUEST, 32'h0000_0000, 7'h00, 1'b0, 3'd5,
          {24'hF0_41_10, 24'h6A_11_00, 24'h00_00_00, 24'h00_00_00, 24'h00_00_F7}},
        // one-byte data-set packet, tail with nothing held
        '{OP_DATA_SET, 32'h0000_0000, 7'h00, 1'b1, 3'd4,
          {24'hF0_41_10, 24'h6A_12_00, 24'h00_00_00, 24'h00_00_F7, 24'h00_00_00}},
        // request with largest size byte
        '{OP_REQUEST, 32'h0000_0000, 7'h7F, 1'b0, 3'd5,
          {24'hF0_41_10, 24'h6A_11_00, 24'h00_00_00, 24'h00_00_00, 24'h7F_01_F7}},
        '{OP_REQUEST,  32'hFFFF_FFFF, 7'h7F, 1'b0, 3'd0, NO_TYPED},
        // held two at the last byte, address changes inside the packet
        '{OP_DATA_SET, 32'h1234_5678, 7'h01, 1'b0, 3'd0, NO_TYPED},
        '{OP_DATA_SET, 32'h0000_0000, 7'h7F, 1'b0, 3'd0, NO_TYPED},
        '{OP_DATA_SET, 32'hFFFF_FFFF, 7'h55, 1'b1, 3'd0, NO_TYPED},
        // held one at the last byte
        '{OP_DATA_SET, 32'hFFFF_FFFF, 7'h7F, 1'b0, 3'd0, NO_TYPED},
        '{OP_DATA_SET, 32'h0000_0000, 7'h00, 1'b1, 3'd0, NO_TYPED},
        // full group, then held one
        '{OP_DATA_SET, 32'h8080_8080, 7'h11, 1'b0, 3'd0, NO_TYPED},
        '{OP_DATA_SET, 32'h0000_0000, 7'h22, 1'b0, 3'd0, NO_TYPED},
        '{OP_DATA_SET, 32'h0000_0000, 7'h33, 1'b0, 3'd0, NO_TYPED},
        '{OP_DATA_SET, 32'h0000_0000, 7'h44, 1'b0, 3'd0, NO_TYPED},
        '{OP_DATA_SET, 32'h0000_0000, 7'h55, 1'b1, 3'd0, NO_TYPED},
        // full group, then nothing held
        '{OP_DATA_SET, 32'hA5A5_A5A5, 7'h01, 1'b0, 3'd0, NO_TYPED},
        '{OP_DATA_SET, 32'h0000_0000, 7'h02, 1'b0, 3'd0, NO_TYPED},
        '{OP_DATA_SET, 32'h0000_0000, 7'h03, 1'b0, 3'd0, NO_TYPED},
        '{OP_DATA_SET, 32'h0000_0000, 7'h04, 1'b1, 3'd0, NO_TYPED},
        // request drops an open packet, last_byte set on it means nothing
        '{OP_DATA_SET, 32'h5A5A_5A5A, 7'h05, 1'b0, 3'd0, NO_TYPED},
        '{OP_DATA_SET, 32'h0000_0000, 7'h06, 1'b0, 3'd0, NO_TYPED},
        '{OP_REQUEST,  32'h0102_0304, 7'h10, 1'b1, 3'd0, NO_TYPED},
        // sum lands on a multiple of 128, checksum must be zero
        '{OP_DATA_SET, 32'h0000_0040, 7'h40, 1'b1, 3'd0, NO_TYPED}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_DEVICE_ID;
    logic [6:0]           cfg_data = 7'h00;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    logic                 op = OP_DATA_SET;
    logic [31:0]          address = 32'h0;
    logic [6:0]           data_value = 7'h00;
    logic                 last_byte = 1'b0;
    logic                 msg_valid;
    logic                 msg_stall = 1'b0;
    logic [1:0]           msg_len;
    logic [7:0]           byte_first;
    logic [7:0]           byte_second;
    logic [7:0]           byte_third;
    logic                 run_end;

    // messages owed by the block, oldest first
    midi_msg_t msgs_due [$];

    // framer state as the predictor sees it
    logic [6:0]  id_device = DEVICE_ID_RST;
    logic [6:0]  id_model  = MODEL_ID_RST;
    logic        pkt_open  = 1'b0;
    logic [31:0] pkt_addr  = 32'h0;
    logic [6:0]  held [2];
    logic [1:0]  held_cnt  = 2'd0;
    logic [6:0]  sum7      = 7'h00;

    int errors = 0;
    int n_items = 0;
    int n_requests = 0;
    int n_msgs = 0;
    int quiet_cycles = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    midi_msg_t got_msg;
    midi_msg_t want_msg;

    sysex_dataset_framer_top i_dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------------

    // address bytes summed, kept mod 128
    function automatic logic [6:0] addr_sum7(input logic [31:0] a);
        logic [9:0] s;
        s = a[7:0] + a[15:8] + a[23:16] + a[31:24];
        return s[6:0];
    endfunction

    // bytes past the length are zero on the port
    function automatic void push_msg(input logic [1:0] len, input logic [7:0] b0,
                                     input logic [7:0] b1, input logic [7:0] b2);
        msgs_due.push_back({len, b0, (len >= 2'd2) ? b1 : 8'h00,
                            (len == 2'd3) ? b2 : 8'h00, 1'b0});
    endfunction

    function automatic void push_header(input logic [31:0] a, input logic [7:0] cmd);
        push_msg(2'd3, SYX_START, SYX_MAKER, {1'b0, id_device});
        push_msg(2'd3, {1'b0, id_model}, cmd, a[31:24]);
        push_msg(2'd3, a[23:16], a[15:8], a[7:0]);
    endfunction

    // messages caused by one input item, run_end set on the last of them
    function automatic void frame_item(input logic o, input logic [31:0] a,
                                       input logic [6:0] d, input logic l);
        int n0;
        logic [6:0] cs;
        midi_msg_t m;
        n0 = msgs_due.size();
        if (o == OP_REQUEST)
        begin
            cs = 7'd0 - (addr_sum7(a) + d);
            // an open data-set packet is dropped
            pkt_open = 1'b0;
            held_cnt = 2'd0;
            push_header(a, CMD_RQ1);
            push_msg(2'd3, 8'h00, 8'h00, 8'h00);
            push_msg(2'd3, {1'b0, d}, {1'b0, cs}, SYX_END);
        end
        else
        begin
            if (!pkt_open)
            begin
                pkt_open = 1'b1;
                pkt_addr = a;
                sum7 = addr_sum7(a);
                held_cnt = 2'd0;
                push_header(pkt_addr, CMD_DT1);
            end
            sum7 = sum7 + d;
            if (!l)
            begin
                if (held_cnt == 2'd2)
                begin
                    push_msg(2'd3, {1'b0, held[0]}, {1'b0, held[1]}, {1'b0, d});
                    held_cnt = 2'd0;
                end
                else
                begin
                    held[held_cnt[0]] = d;
                    held_cnt = held_cnt + 2'd1;
                end
            end
            else
            begin
                cs = 7'd0 - sum7;
                case (held_cnt)
                    2'd2:
                    begin
                        push_msg(2'd3, {1'b0, held[0]}, {1'b0, held[1]}, {1'b0, d});
                        push_msg(2'd2, {1'b0, cs}, SYX_END, 8'h00);
                    end
                    2'd1:
                    begin
                        push_msg(2'd3, {1'b0, held[0]}, {1'b0, d}, {1'b0, cs});
                        push_msg(2'd1, SYX_END, 8'h00, 8'h00);
                    end
                    default:
                    begin
                        push_msg(2'd3, {1'b0, d}, {1'b0, cs}, SYX_END);
                    end
                endcase
                pkt_open = 1'b0;
                held_cnt = 2'd0;
            end
        end
        if (msgs_due.size() > n0)
        begin
            m = msgs_due.pop_back();
            m.run_end = 1'b1;
            msgs_due.push_back(m);
        end
    endfunction

    // ---------------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------------

    // receiver backpressure, redrawn every cycle
    always @(posedge clk)
    begin
        msg_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // random idle cycles, then present the item and hold it until taken;
    // valid stays high afterwards so back-to-back items never drop it
    task automatic send_item(input logic o, input logic [31:0] a, input logic [6:0] d,
                             input logic l, input logic [2:0] n_typed,
                             input logic [0:4][23:0] typed);
        int n0;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        // expectations go in before the item can be taken, so a fast
        // result never finds the store empty
        n0 = msgs_due.size();
        frame_item(o, a, d, l);
        if (n_typed != 3'd0)
        begin
            while (msgs_due.size() > n0)
                void'(msgs_due.pop_back());
            for (int k = 0; k < n_typed; k++)
                msgs_due.push_back({2'd3, typed[k], k == n_typed - 1});
        end
        item_valid <= 1'b1;
        op         <= o;
        address    <= a;
        data_value <= d;
        last_byte  <= l;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        n_items++;
        if (o == OP_REQUEST)
            n_requests++;
    endtask

    // mostly whole data-set packets of one to eight bytes, some requests
    // landing anywhere, some loose bytes with a random last flag
    task automatic send_random_items(input int count);
        int r;
        int left;
        logic o;
        logic [6:0] d;
        logic l;
        left = 0;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            d = 7'($urandom_range(0, 127));
            if (r < 10)
            begin
                o = OP_REQUEST;
                l = 1'($urandom_range(0, 1));
                left = 0;
            end
            else if (r < 16)
            begin
                o = OP_DATA_SET;
                l = 1'($urandom_range(0, 1));
                if (l)
                    left = 0;
            end
            else
            begin
                o = OP_DATA_SET;
                if (left == 0)
                    left = $urandom_range(1, 8);
                l = (left == 1);
                left--;
            end
            send_item(o, $urandom, d, l, 3'd0, NO_TYPED);
        end
    endtask

    // both id registers, valid held high across the pair
    task automatic set_ids(input logic [6:0] dev, input logic [6:0] model);
        for (int k = 0; k < 2; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= (k == 0) ? REG_DEVICE_ID : REG_MODEL_ID;
            cfg_data  <= (k == 0) ? dev : model;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        id_device = dev;
        id_model  = model;
    endtask

    // wait for every owed message, then let a byte that only fills a group
    // work its way through
    task automatic settle();
        while (msgs_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ---------------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && msg_valid && !msg_stall)
        begin
            got_msg = {msg_len, byte_first, byte_second, byte_third, run_end};
            if (msgs_due.size() == 0)
            begin
                $display("%0t: message with none expected, got %h", $time, got_msg);
                errors++;
            end
            else
            begin
                want_msg = msgs_due.pop_front();
                check_field("msg_len", 8'(want_msg.len), 8'(got_msg.len));
                check_field("byte_first", want_msg.b0, got_msg.b0);
                check_field("byte_second", want_msg.b1, got_msg.b1);
                check_field("byte_third", want_msg.b2, got_msg.b2);
                check_field("run_end", 8'(want_msg.run_end), 8'(got_msg.run_end));
                n_msgs++;
            end
        end
    end

    // hang detection: any handshake on any channel resets the count
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (msg_valid && !msg_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d messages still owed",
                     $time, QUIET_LIMIT, msgs_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------------

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows at reset ids, no idling on either side
        for (int r = 0; r < N_DIRECTED; r++)
            send_item(DIRECTED[r].op, DIRECTED[r].addr, DIRECTED[r].data,
                      DIRECTED[r].last, DIRECTED[r].n_typed, DIRECTED[r].typed);
        item_valid <= 1'b0;
        settle();

        // random phases, each with its own ids and handshake mix
        for (int p = 0; p < N_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    set_ids(7'h00, 7'h7F);
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    set_ids(7'h7F, 7'h00);
                    send_idle_pct = 88;
                    stall_pct = 0;
                end
                2:
                begin
                    set_ids(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
                    send_idle_pct = 0;
                    stall_pct = 88;
                end
                3:
                begin
                    set_ids(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
                    send_idle_pct = 16;
                    stall_pct = 16;
                end
                default:
                begin
                    set_ids(7'h7F, 7'h7F);
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
            endcase
            send_random_items(ITEMS_PER_PHASE);
            item_valid <= 1'b0;
            settle();
        end

        $display("framed %0d items (%0d requests) into %0d checked messages",
                 n_items, n_requests, n_msgs);
        $display("ids at reset, both extremes and random; idle and stall mixes varied");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- sysex_dataset_framer_top.f -----
+incdir+design
design/sdf_pkg.sv
design/sdf_front.sv
design/sdf_queue.sv
design/sdf_back.sv
design/sysex_dataset_framer_top.sv
tb/tb_sysex_dataset_framer_top.sv
